### src/whp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_pkg - shared types and constants of the wav header parser
// result record, status codes and format codes
// ----------------------------------------------------------------------------
package whp_pkg;

    localparam int STATUS_W = 2;
    localparam int FORMAT_W = 3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RIFF  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_WAVE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd3;

    // format codes
    localparam logic [FORMAT_W-1:0] FC_UNKNOWN  = 3'd0;
    localparam logic [FORMAT_W-1:0] FC_MONO8    = 3'd1;
    localparam logic [FORMAT_W-1:0] FC_MONO16   = 3'd2;
    localparam logic [FORMAT_W-1:0] FC_STEREO8  = 3'd3;
    localparam logic [FORMAT_W-1:0] FC_STEREO16 = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FORMAT_W-1:0] format_code;
        logic                fmt_seen;
        logic [31:0]         rate_hz;
        logic [15:0]         channel_count;
        logic [15:0]         sample_bits;
        logic [31:0]         data_size;
        logic [31:0]         data_offset;
    } t_result;

endpackage

### src/whp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_parse_core - byte-wise riff/wave chunk walker
// updates the parse state for each accepted byte and flags a result
// ----------------------------------------------------------------------------
module whp_parse_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_first,
    input  logic             i_last,
    output logic             o_res_valid,
    output whp_pkg::t_result o_res
);

    localparam logic [3:0] PH_RIFF_ID    = 4'd0;
    localparam logic [3:0] PH_RIFF_SIZE  = 4'd1;
    localparam logic [3:0] PH_WAVE_ID    = 4'd2;
    localparam logic [3:0] PH_CHUNK_ID   = 4'd3;
    localparam logic [3:0] PH_SIZE_FMT   = 4'd4;
    localparam logic [3:0] PH_SIZE_DATA  = 4'd5;
    localparam logic [3:0] PH_SIZE_OTHER = 4'd6;
    localparam logic [3:0] PH_FMT_BODY   = 4'd7;
    localparam logic [3:0] PH_SKIP       = 4'd8;

    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [3:0]  FMT_LAST_K   = 4'd15;

    logic [3:0]  r_phase,  n_phase,  b_phase;
    logic [31:0] r_pos,    n_pos,    b_pos;
    logic [4:0]  r_field,  n_field,  b_field;
    logic [31:0] r_gather, n_gather, b_gather;
    logic [31:0] r_clen,   n_clen,   b_clen;
    logic [31:0] r_skip,   n_skip,   b_skip;
    logic [15:0] r_kind,   n_kind,   b_kind;
    logic [15:0] r_chan,   n_chan,   b_chan;
    logic [31:0] r_rate,   n_rate,   b_rate;
    logic [15:0] r_bits,   n_bits,   b_bits;
    logic        r_fmt,    n_fmt,    b_fmt;
    logic        r_done,   n_done,   b_done;

    function automatic logic [whp_pkg::FORMAT_W-1:0] format_of(
        input logic        fmt,
        input logic [15:0] kind,
        input logic [15:0] chan,
        input logic [15:0] bits
    );
        logic [whp_pkg::FORMAT_W-1:0] fc;
        fc = whp_pkg::FC_UNKNOWN;
        if (fmt && kind == 16'd1) begin
            if (chan == 16'd1) begin
                if (bits == 16'd8)       fc = whp_pkg::FC_MONO8;
                else if (bits == 16'd16) fc = whp_pkg::FC_MONO16;
            end else if (chan == 16'd2) begin
                if (bits == 16'd8)       fc = whp_pkg::FC_STEREO8;
                else if (bits == 16'd16) fc = whp_pkg::FC_STEREO16;
            end
        end
        return fc;
    endfunction

    // restart view of the state: a first byte clears everything
    always_comb begin
        b_phase  = i_first ? PH_RIFF_ID : r_phase;
        b_pos    = i_first ? '0 : r_pos;
        b_field  = i_first ? '0 : r_field;
        b_gather = i_first ? '0 : r_gather;
        b_clen   = i_first ? '0 : r_clen;
        b_skip   = i_first ? '0 : r_skip;
        b_kind   = i_first ? '0 : r_kind;
        b_chan   = i_first ? '0 : r_chan;
        b_rate   = i_first ? '0 : r_rate;
        b_bits   = i_first ? '0 : r_bits;
        b_fmt    = i_first ? 1'b0 : r_fmt;
        b_done   = i_first ? 1'b0 : r_done;
    end

    logic [31:0] w_big, w_little, w_byte32;
    logic        w_word_done;
    logic [3:0]  w_k;

    assign w_byte32    = {24'd0, i_data_byte};
    assign w_big       = {b_gather[23:0], i_data_byte};
    assign w_little    = b_gather | (w_byte32 << {b_field[1:0], 3'b000});
    assign w_word_done = (b_field[1:0] == 2'd3);
    assign w_k         = b_field[3:0];

    always_comb begin
        n_phase = r_phase;  n_pos  = r_pos;  n_field = r_field; n_gather = r_gather;
        n_clen  = r_clen;   n_skip = r_skip; n_kind  = r_kind;  n_chan   = r_chan;
        n_rate  = r_rate;   n_bits = r_bits; n_fmt   = r_fmt;   n_done   = r_done;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            n_phase = b_phase;  n_pos  = b_pos;  n_field = b_field; n_gather = b_gather;
            n_clen  = b_clen;   n_skip = b_skip; n_kind  = b_kind;  n_chan   = b_chan;
            n_rate  = b_rate;   n_bits = b_bits; n_fmt   = b_fmt;   n_done   = b_done;

            if (!b_done) begin
                n_pos = (b_pos == 32'hFFFF_FFFF) ? b_pos : b_pos + 32'd1;

                unique case (b_phase)
                    PH_RIFF_ID, PH_WAVE_ID, PH_CHUNK_ID: begin
                        n_gather = w_big;
                        n_field  = b_field + 5'd1;
                        if (w_word_done) begin
                            n_field  = '0;
                            n_gather = '0;
                            if (b_phase == PH_RIFF_ID) begin
                                if (w_big != ID_RIFF) begin
                                    o_res_valid   = 1'b1;
                                    o_res.status  = whp_pkg::ST_NO_RIFF;
                                    n_done        = 1'b1;
                                end else begin
                                    n_phase = PH_RIFF_SIZE;
                                end
                            end else if (b_phase == PH_WAVE_ID) begin
                                if (w_big != ID_WAVE) begin
                                    o_res_valid   = 1'b1;
                                    o_res.status  = whp_pkg::ST_NO_WAVE;
                                    n_done        = 1'b1;
                                end else begin
                                    n_phase = PH_CHUNK_ID;
                                end
                            end else if (w_big == ID_FMT) begin
                                n_phase = PH_SIZE_FMT;
                            end else if (w_big == ID_DATA) begin
                                n_phase = PH_SIZE_DATA;
                            end else begin
                                n_phase = PH_SIZE_OTHER;
                            end
                        end
                    end
                    PH_RIFF_SIZE: begin
                        n_gather = w_little;
                        n_field  = b_field + 5'd1;
                        if (w_word_done) begin
                            n_field  = '0;
                            n_gather = '0;
                            n_phase  = PH_WAVE_ID;
                        end
                    end
                    PH_SIZE_FMT, PH_SIZE_DATA, PH_SIZE_OTHER: begin
                        n_gather = w_little;
                        n_field  = b_field + 5'd1;
                        if (w_word_done) begin
                            n_field  = '0;
                            n_gather = '0;
                            n_clen   = w_little;
                            if (b_phase == PH_SIZE_FMT) begin
                                n_phase = PH_FMT_BODY;
                            end else if (b_phase == PH_SIZE_DATA) begin
                                o_res_valid         = 1'b1;
                                o_res.status        = whp_pkg::ST_OK;
                                o_res.format_code   = format_of(b_fmt, b_kind, b_chan, b_bits);
                                o_res.fmt_seen      = b_fmt;
                                o_res.rate_hz       = b_fmt ? b_rate : '0;
                                o_res.channel_count = b_fmt ? b_chan : '0;
                                o_res.sample_bits   = b_fmt ? b_bits : '0;
                                o_res.data_size     = w_little;
                                o_res.data_offset   = n_pos;
                                n_done              = 1'b1;
                            end else if (w_little == '0) begin
                                n_phase = PH_CHUNK_ID;
                            end else begin
                                n_skip  = w_little;
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_FMT_BODY: begin
                        case (w_k) inside
                            4'd0: begin
                                n_kind = {8'd0, i_data_byte};
                                n_chan = '0;
                                n_rate = '0;
                                n_bits = '0;
                            end
                            4'd1:          n_kind = {i_data_byte, b_kind[7:0]};
                            4'd2:          n_chan = {8'd0, i_data_byte};
                            4'd3:          n_chan = {i_data_byte, b_chan[7:0]};
                            [4'd4:4'd7]:   n_rate = b_rate | (w_byte32 << {w_k[1:0], 3'b000});
                            4'd14:         n_bits = {8'd0, i_data_byte};
                            4'd15:         n_bits = {i_data_byte, b_bits[7:0]};
                            default:       ;
                        endcase
                        n_field = b_field + 5'd1;
                        if (w_k == FMT_LAST_K) begin
                            n_field = '0;
                            n_fmt   = 1'b1;
                            if (b_clen > FMT_BODY_LEN) begin
                                n_skip  = b_clen - FMT_BODY_LEN;
                                n_phase = PH_SKIP;
                            end else begin
                                n_phase = PH_CHUNK_ID;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip = (b_skip != '0) ? b_skip - 32'd1 : b_skip;
                        if (n_skip == '0) n_phase = PH_CHUNK_ID;
                    end
                    default: n_phase = PH_CHUNK_ID;
                endcase

                // stream ran out before the data chunk header
                if (!o_res_valid && i_last && !n_done) begin
                    o_res_valid  = 1'b1;
                    o_res        = '0;
                    o_res.status = whp_pkg::ST_TRUNC;
                    n_done       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF_ID; r_pos  <= '0; r_field <= '0; r_gather <= '0;
            r_clen  <= '0;         r_skip <= '0; r_kind  <= '0; r_chan   <= '0;
            r_rate  <= '0;         r_bits <= '0; r_fmt   <= 1'b0; r_done <= 1'b0;
        end else begin
            r_phase <= n_phase; r_pos  <= n_pos;  r_field <= n_field; r_gather <= n_gather;
            r_clen  <= n_clen;  r_skip <= n_skip; r_kind  <= n_kind;  r_chan   <= n_chan;
            r_rate  <= n_rate;  r_bits <= n_bits; r_fmt   <= n_fmt;   r_done   <= n_done;
        end
    end

    // a result always closes the file
    a_result_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_done)
        else $error("result given without closing the file");

    // a closed file stays silent until restarted
    a_silent_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_done && !i_first) |-> !o_res_valid)
        else $error("result after the file was closed");

    // fmt body index never runs past its sixteen bytes
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field < 5'd16)
        else $error("field counter out of range");

endmodule

### src/wav_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser - streaming riff/wave header parser
// one byte per transaction in, at most one header summary per file out
// ----------------------------------------------------------------------------
// output: the summary is registered into the output buffer from the byte that
//   completes the data chunk header (or that ends the file or fails a check)
// throughput: one byte per cycle while the skid entry is empty;
//   a two-entry output buffer keeps input flowing while a summary waits
// reset: synchronous, active low; clears the parser to expect "RIFF" and
//   empties the output buffer
// ----------------------------------------------------------------------------
module wav_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream in
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tuser,   // [0] first_byte
    input  logic         i_s_axis_tlast,   // last_byte
    // header summary out
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [2:0] format_code, [3] fmt_seen, [35:4] rate_hz, [51:36] channel_count,
    // [67:52] sample_bits, [99:68] data_size, [131:100] data_offset, [135:132] zero
    output logic [135:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser    // [1:0] status
);

    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    whp_pkg::t_result w_res;

    // output buffer: head is what the master side sees, skid catches overflow
    logic             r_head_valid;
    whp_pkg::t_result r_head;
    logic             r_skid_valid;
    whp_pkg::t_result r_skid;

    // ready only depends on the registered skid flag
    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = r_head_valid && i_m_axis_tready;

    whp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_s_axis_tdata),
        .i_first     (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .o_res_valid (w_push),
        .o_res       (w_res)
    );

    // head / skid bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_head_valid <= w_push;
            end
        end else if (w_push) begin
            if (!r_head_valid) r_head_valid <= 1'b1;
            else               r_skid_valid <= 1'b1;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) r_head <= r_skid;
            else if (w_push)  r_head <= w_res;
        end else if (w_push) begin
            if (!r_head_valid) r_head <= w_res;
            else               r_skid <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_head_valid;
    assign o_m_axis_tuser  = r_head.status;
    assign o_m_axis_tdata  = {4'd0,
                              r_head.data_offset,
                              r_head.data_size,
                              r_head.sample_bits,
                              r_head.channel_count,
                              r_head.rate_hz,
                              r_head.fmt_seen,
                              r_head.format_code};

    // skid only ever holds a transaction behind a waiting head
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid entry without head entry");

    // draining the skid moves it into the head
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_pop) |=> (r_head_valid && !r_skid_valid))
        else $error("skid entry lost on drain");

    // a waiting summary holds still until it is taken
    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("summary changed while stalled");

endmodule
